>>> rtl/signed_int_to_decimal_ascii_core_assert.svh
// Assertion macros used by the converter's serializer module
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define SIDC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define SIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sidc_pkg.sv
// Package: widths, character codes and pipeline data types of the converter
`default_nettype none
package sidc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int ITERS = 4;
  localparam int DD_STAGES = (VALUE_BITS + ITERS - 1) / ITERS;
  localparam int BIN_W = DD_STAGES * ITERS;
  localparam int CNT_W = $clog2(DIGITS);

  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef logic [DIGITS-1:0][3:0] sidc_bcd_t;

  typedef struct packed {
    logic             neg;
    sidc_bcd_t        bcd;
    logic [BIN_W-1:0] bin;
  } sidc_work_t;

endpackage
`default_nettype wire

>>> rtl/sidc_mag_stage.sv
// Sign split and magnitude register, first pipeline stage
`default_nettype none
module sidc_mag_stage import sidc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  logic signed [VALUE_BITS-1:0] up_value,
  output logic                         up_ready,
  output logic                         dn_valid,
  output sidc_work_t                   dn_data,
  input  logic                         dn_ready
);

  logic            valid_r;
  sidc_work_t      data_r;
  sidc_work_t      data_nxt;
  logic [VALUE_BITS-1:0] mag;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    mag = up_value[VALUE_BITS-1] ? (~up_value + 1'b1) : up_value;
    data_nxt.neg = up_value[VALUE_BITS-1];
    data_nxt.bcd = '0;
    data_nxt.bin = BIN_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;

endmodule
`default_nettype wire

>>> rtl/sidc_dd_stage.sv
// One shift-and-add-3 binary to BCD stage of the conversion pipeline
`default_nettype none
module sidc_dd_stage import sidc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  sidc_work_t up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output sidc_work_t dn_data,
  input  logic       dn_ready
);

  localparam int ACC_W = DIGITS * 4 + BIN_W;

  logic       valid_r;
  sidc_work_t data_r;
  sidc_work_t data_nxt;
  logic [ACC_W-1:0] acc;
  logic [3:0]       dig;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    acc = {up_data.bcd, up_data.bin};
    dig = '0;
    for (int it = 0; it < ITERS; it++) begin
      for (int d = 0; d < DIGITS; d++) begin
        dig = acc[BIN_W + d*4 +: 4];
        if (dig >= 4'd5) begin
          acc[BIN_W + d*4 +: 4] = dig + 4'd3;
        end
      end
      acc = acc << 1;
    end
    data_nxt.neg = up_data.neg;
    data_nxt.bcd = acc[BIN_W +: DIGITS*4];
    data_nxt.bin = acc[BIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;

endmodule
`default_nettype wire

>>> rtl/sidc_serializer.sv
// Character serializer: sign, then digits from the leading nonzero one
`default_nettype none
`include "signed_int_to_decimal_ascii_core_assert.svh"
module sidc_serializer import sidc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  sidc_work_t up_data,
  output logic       up_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_ascii_char,
  output logic       out_last_char
);

  logic             busy_r, busy_nxt;
  logic             sign_r, sign_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sidc_bcd_t        bcd_r;
  logic [CNT_W-1:0] top;
  logic             take_out;
  logic             is_last;
  logic             load;

  assign take_out = busy_r && !out_stall;
  assign is_last = !sign_r && (cnt_r == '0);
  assign up_ready = !busy_r || (take_out && is_last);
  assign load = up_valid && up_ready;

  always_comb begin
    top = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (up_data.bcd[d] != 4'd0) begin
        top = CNT_W'(d);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    sign_nxt = sign_r;
    cnt_nxt = cnt_r;
    if (take_out) begin
      priority if (sign_r) begin
        sign_nxt = 1'b0;
      end else if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      sign_nxt = up_data.neg;
      cnt_nxt = top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      sign_r <= sign_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= up_data.bcd;
    end
  end

  assign out_valid = busy_r;
  assign out_ascii_char = sign_r ? CHAR_MINUS : (CHAR_ZERO + {2'b00, bcd_r[cnt_r]});
  assign out_last_char = is_last;

  `SIDC_ASSERT_IMP(a_sign_not_last, busy_r && sign_r, !out_last_char,
    "minus sign flagged as last character")
  `SIDC_ASSERT_NEXT(a_neg_sign_first, load && up_data.neg,
    busy_r && sign_r && out_ascii_char == CHAR_MINUS,
    "negative request does not start with minus sign")
  `SIDC_ASSERT_NEXT(a_digit_advance, take_out && !sign_r && cnt_r != '0,
    busy_r && cnt_r == $past(cnt_r) - 1'b1,
    "digit index did not advance by one")

endmodule
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii_core.sv
// Top level: signed integer to decimal ASCII character stream
//
// Input channel: in_valid, in_value (signed two's complement), in_stall.
// Output channel: out_valid, out_ascii_char, out_last_char, out_stall.
// Each request yields its decimal text, most significant character first:
// a minus sign for negative values, then the digits without leading zeros
// (zero gives a single '0'). out_last_char marks the final character.
// Path from request acceptance to the first character: one magnitude stage,
// eight BCD stages of four shift steps each, then the serializer load.
// Throughput: while out_stall is low the serializer sends one character
// per cycle, so a request occupies it for its digits plus sign; the next
// request's first character follows the previous last character directly.
// Up to nine requests wait in the conversion pipeline meanwhile.
// Reset clears all valid flags; no clearing pass is needed.
// While out_stall is high the current character holds, the pipeline fills
// and then raises in_stall; nothing is dropped or repeated.
`default_nettype none
module signed_int_to_decimal_ascii_core import sidc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [5:0]                   out_ascii_char,
  output logic                         out_last_char
);

  logic       mag_ready;
  logic       st_valid [DD_STAGES+1];
  sidc_work_t st_data  [DD_STAGES+1];
  logic       st_ready [DD_STAGES+1];

  assign in_stall = !mag_ready;

  sidc_mag_stage u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_value (in_value),
    .up_ready (mag_ready),
    .dn_valid (st_valid[0]),
    .dn_data  (st_data[0]),
    .dn_ready (st_ready[0])
  );

  for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
    sidc_dd_stage u_dd (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[s]),
      .up_data  (st_data[s]),
      .up_ready (st_ready[s]),
      .dn_valid (st_valid[s+1]),
      .dn_data  (st_data[s+1]),
      .dn_ready (st_ready[s+1])
    );
  end

  sidc_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (st_valid[DD_STAGES]),
    .up_data        (st_data[DD_STAGES]),
    .up_ready       (st_ready[DD_STAGES]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

endmodule
`default_nettype wire

>>> test/signed_int_to_decimal_ascii_core_tb.sv
// Testbench: random and directed integers checked against predicted decimal ASCII text
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_core_tb;
  import sidc_pkg::*;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM = 456;
  localparam int TAIL_ITEMS = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    bit                           drain;
  } request_t;

  typedef struct {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [5:0]                   out_ascii_char;
  logic                         out_last_char;

  request_t   pending_values[$];
  text_char_t expected_text[$];

  bit req_taken = 1'b0;
  bit tail_phase = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int values_taken = 0;
  int negatives_taken = 0;
  int chars_checked = 0;

  logic signed [VALUE_BITS-1:0] directed_vals [N_DIRECTED] = '{
    0, 1, -1, 7, -8, 9, 10, -10, 99, 100, -100, 101, 12345, -67890,
    999999999, 1000000000, -999999999, -1000000000, 1234567890, -1234567890,
    2147483647, -2147483647, 32'sh8000_0000, 2147483646
  };

  signed_int_to_decimal_ascii_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic push_decimal_text(input logic signed [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    int                    digits[$];
    text_char_t            ch;
    mag = value;
    if (value[VALUE_BITS-1]) begin
      mag = ~mag + 1'b1;
    end
    do begin
      digits.push_front(int'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = CHAR_ZERO + 6'(digits[i]);
      ch.last = (i == digits.size() - 1);
      expected_text.push_back(ch);
    end
  endtask

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    int unsigned kind;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    kind = $urandom_range(0, 7);
    if (kind < 2) return $urandom;
    if (kind == 2) begin
      if ($urandom_range(0, 1)) return 32'sh8000_0000 + $urandom_range(0, 3);
      return 32'sh7fff_ffff - $urandom_range(0, 3);
    end
    if (kind == 3) return $urandom_range(0, 40) - 20;
    ndig = $urandom_range(1, 10);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = (ndig == 10) ? 32'd2147483647 : lo * 10 - 1;
    if (ndig == 1) lo = 0;
    mag = $urandom_range(hi, lo);
    if ($urandom_range(0, 1)) return -$signed(mag);
    return mag;
  endfunction

  // driver: present the next request at the falling edge
  always @(negedge clk) begin
    bit       send;
    request_t next_req;
    send = 1'b0;
    next_req.value = '0;
    next_req.drain = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_values.size() != 0 &&
                   !(pending_values[0].drain && expected_text.size() != 0)) begin
        if (!tail_phase && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 18);
        end else begin
          next_req = pending_values.pop_front();
          send = 1'b1;
        end
      end
      in_valid <= send;
      in_value <= send ? next_req.value : $urandom;
    end
  end

  // receiver: stall the character stream in bursts
  always @(negedge clk) begin
    if (stall_left == 0 && !tail_phase && rst_n && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check characters, then predict text for each accepted request
  always @(posedge clk) begin
    text_char_t want;
    cycle_count++;
    tail_phase = pending_values.size() < TAIL_ITEMS;
    req_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d last %0b",
                                  out_ascii_char, out_last_char));
      end else begin
        want = expected_text.pop_front();
        if (out_ascii_char !== want.code) begin
          report_mismatch($sformatf("ascii_char %0d, want %0d", out_ascii_char, want.code));
        end
        if (out_last_char !== want.last) begin
          report_mismatch($sformatf("last_char %0b, want %0b", out_last_char, want.last));
        end
      end
    end
    if (req_taken) begin
      values_taken++;
      if (in_value[VALUE_BITS-1]) negatives_taken++;
      push_decimal_text(in_value);
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d chars outstanding",
               cycle_count, expected_text.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    request_t req;
    foreach (directed_vals[i]) begin
      req.value = directed_vals[i];
      req.drain = 1'b0;
      pending_values.push_back(req);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      req.value = random_value();
      req.drain = (i == 0) || (i == N_RANDOM / 2);
      pending_values.push_back(req);
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    while (pending_values.size() != 0 || in_valid || expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("converted %0d values (%0d negative), checked %0d characters",
             values_taken, negatives_taken, chars_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sidc_pkg.sv
rtl/sidc_mag_stage.sv
rtl/sidc_dd_stage.sv
rtl/sidc_serializer.sv
rtl/signed_int_to_decimal_ascii_core.sv
test/signed_int_to_decimal_ascii_core_tb.sv
